### rtl/tml_pkg.sv
// tml_pkg: shared types, codes and character classes for the text mesh lexer
// no dependencies; imported by the channel interfaces and text_mesh_lexer
package tml_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int OFFSET_BITS = 32;
  localparam int LINE_BITS   = 32;

  localparam int TYPE_W  = 5;
  localparam int START_W = 32;
  localparam int TLEN_W  = 16;
  localparam int LINE_W  = 32;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // lexer modes
  localparam logic [3:0] M_IDLE       = 4'd0;
  localparam logic [3:0] M_SLASH      = 4'd1;
  localparam logic [3:0] M_COMMENT    = 4'd2;
  localparam logic [3:0] M_IDENT      = 4'd3;
  localparam logic [3:0] M_NUMBER     = 4'd4;
  localparam logic [3:0] M_STRING     = 4'd5;
  localparam logic [3:0] M_CHAR_BODY  = 4'd6;
  localparam logic [3:0] M_CHAR_CLOSE = 4'd7;
  localparam logic [3:0] M_ERROR      = 4'd8;

  // token kinds
  localparam logic [TYPE_W-1:0] TOK_IDENT    = 5'd0;
  localparam logic [TYPE_W-1:0] TOK_NUMBER   = 5'd1;
  localparam logic [TYPE_W-1:0] TOK_STRING   = 5'd2;
  localparam logic [TYPE_W-1:0] TOK_LBRACE   = 5'd3;
  localparam logic [TYPE_W-1:0] TOK_RBRACE   = 5'd4;
  localparam logic [TYPE_W-1:0] TOK_LPAREN   = 5'd5;
  localparam logic [TYPE_W-1:0] TOK_RPAREN   = 5'd6;
  localparam logic [TYPE_W-1:0] TOK_LBRACKET = 5'd7;
  localparam logic [TYPE_W-1:0] TOK_RBRACKET = 5'd8;
  localparam logic [TYPE_W-1:0] TOK_COMMA    = 5'd9;
  localparam logic [TYPE_W-1:0] TOK_EQUALS   = 5'd10;
  localparam logic [TYPE_W-1:0] TOK_SEMI     = 5'd11;
  localparam logic [TYPE_W-1:0] TOK_STAR     = 5'd12;
  localparam logic [TYPE_W-1:0] TOK_GREATER  = 5'd13;
  localparam logic [TYPE_W-1:0] TOK_LESS     = 5'd14;
  localparam logic [TYPE_W-1:0] TOK_FSLASH   = 5'd15;
  localparam logic [TYPE_W-1:0] TOK_BSLASH   = 5'd16;
  localparam logic [TYPE_W-1:0] TOK_AT       = 5'd17;
  localparam logic [TYPE_W-1:0] TOK_BANG     = 5'd18;
  localparam logic [TYPE_W-1:0] TOK_PIPE     = 5'd20;
  localparam logic [TYPE_W-1:0] TOK_AMP      = 5'd21;
  localparam logic [TYPE_W-1:0] TOK_PLUS     = 5'd22;
  localparam logic [TYPE_W-1:0] TOK_MINUS    = 5'd23;
  localparam logic [TYPE_W-1:0] TOK_COLON    = 5'd24;
  localparam logic [TYPE_W-1:0] TOK_HASH     = 5'd25;
  localparam logic [TYPE_W-1:0] TOK_DOT      = 5'd26;
  localparam logic [TYPE_W-1:0] TOK_CHAR     = 5'd27;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  typedef struct packed {
    logic              hit;
    logic [TYPE_W-1:0] kind;
  } punct_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  token_type;
    logic [START_W-1:0] token_start;
    logic [TLEN_W-1:0]  token_length;
    logic [LINE_W-1:0]  token_line;
    logic               error_flag;
    logic [7:0]         bad_byte;
    logic               file_end;
    logic               run_last;
  } result_t;

  function automatic logic is_alpha_(input logic [7:0] b);
    return (b >= CH_UA && b <= CH_UZ) || (b >= CH_LA && b <= CH_LZ) || b == CH_UNDER;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  function automatic punct_t punct_kind(input logic [7:0] b);
    punct_t p;
    p.hit = 1'b1;
    case (b)
      8'h7B: p.kind = TOK_LBRACE;
      8'h7D: p.kind = TOK_RBRACE;
      8'h28: p.kind = TOK_LPAREN;
      8'h29: p.kind = TOK_RPAREN;
      8'h5B: p.kind = TOK_LBRACKET;
      8'h5D: p.kind = TOK_RBRACKET;
      8'h2C: p.kind = TOK_COMMA;
      8'h3D: p.kind = TOK_EQUALS;
      8'h3B: p.kind = TOK_SEMI;
      8'h2A: p.kind = TOK_STAR;
      8'h3E: p.kind = TOK_GREATER;
      8'h3C: p.kind = TOK_LESS;
      8'h5C: p.kind = TOK_BSLASH;
      8'h40: p.kind = TOK_AT;
      8'h21: p.kind = TOK_BANG;
      8'h7C: p.kind = TOK_PIPE;
      8'h26: p.kind = TOK_AMP;
      8'h2B: p.kind = TOK_PLUS;
      8'h2D: p.kind = TOK_MINUS;
      8'h3A: p.kind = TOK_COLON;
      8'h23: p.kind = TOK_HASH;
      8'h2E: p.kind = TOK_DOT;
      default: begin
        p.hit  = 1'b0;
        p.kind = TOK_IDENT;
      end
    endcase
    return p;
  endfunction

endpackage

### rtl/tml_if.sv
// tml_if: valid/ready channels for the text mesh lexer (byte in, token word out)
// depends on tml_pkg for field widths
interface tml_in_if import tml_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface tml_out_if import tml_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TYPE_W-1:0]  token_type;
  logic [START_W-1:0] token_start;
  logic [TLEN_W-1:0]  token_length;
  logic [LINE_W-1:0]  token_line;
  logic               error_flag;
  logic [7:0]         bad_byte;
  logic               file_end;
  logic               run_last;

  modport source(output valid, output token_type, output token_start, output token_length,
                 output token_line, output error_flag, output bad_byte, output file_end,
                 output run_last, input ready);
  modport sink(input valid, input token_type, input token_start, input token_length,
               input token_line, input error_flag, input bad_byte, input file_end,
               input run_last, output ready);
endinterface

### rtl/text_mesh_lexer.sv
// text_mesh_lexer: streaming tokenizer for text mesh files, one byte per word
// depends on tml_pkg and the tml_in_if / tml_out_if channels
//
// usage:
//   in_ch carries the file one byte per word; last_byte marks the final byte,
//   which flushes any pending token and returns the lexer to its reset state
//   so the next word starts a new file.
//   out_ch carries one word per token (or one error word for the first bad
//   byte, after which bytes are ignored until the final byte); run_last marks
//   the last word caused by an input byte, file_end the last word caused by a
//   final byte. a byte is lexed in the cycle it is accepted; its zero, one or
//   two words land in a four-entry result queue, from whose registers out_ch
//   is driven, oldest first. throughput is one byte per cycle; out_ch
//   drains one word at a time, and in_ch.ready drops while fewer than two
//   queue entries are free, so a stalled receiver backs up into the byte
//   stream without losing words.
//   after reset: queue empty, line 1, offset 0, lexer between tokens.
module text_mesh_lexer import tml_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  tml_in_if.sink    in_ch,
  tml_out_if.source out_ch
);

  // lexer state
  logic [3:0]             mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic                   bsl_r, bsl_nxt;
  logic [LINE_BITS-1:0]   sline_r, sline_nxt;

  // result queue
  result_t              fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0]   count_r, count_nxt;

  logic       accept, pop;
  logic [7:0] b;
  logic       last;
  logic       do_idle, cont;
  punct_t     pk;
  logic       em_a_v, em_b_v, em_c_v;
  result_t    em_a, em_b, em_c, res0, res1;
  logic [1:0] n_res;
  logic [LINE_BITS-1:0]   line_inc;
  logic [LENGTH_BITS-1:0] len_inc;

  assign accept = in_ch.valid && in_ch.ready;
  assign pop    = out_ch.valid && out_ch.ready;
  assign b      = in_ch.data_byte;
  assign last   = in_ch.last_byte;

  assign in_ch.ready = count_r <= FIFO_CW'(FIFO_DEPTH - 2);

  assign line_inc = (line_r == LINE_MAX) ? line_r : line_r + 1'b1;
  assign len_inc  = (len_r == LEN_MAX) ? len_r : len_r + 1'b1;
  assign pk       = punct_kind(b);

  always_comb begin
    mode_nxt  = mode_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    line_nxt  = line_r;
    off_nxt   = off_r;
    bsl_nxt   = bsl_r;
    sline_nxt = sline_r;
    do_idle   = 1'b0;
    cont      = 1'b0;
    em_a_v    = 1'b0;
    em_b_v    = 1'b0;
    em_c_v    = 1'b0;
    em_a      = '0;
    em_b      = '0;
    em_c      = '0;

    // token in progress: continue or close it
    em_a.token_start = START_W'(start_r);
    em_a.token_line  = LINE_W'(sline_r);
    case (mode_r)
      M_IDENT, M_NUMBER: begin
        cont = (mode_r == M_IDENT) ? (is_alpha_(b) || is_digit(b))
                                   : (is_digit(b) || b == CH_DOT);
        if (cont) begin
          len_nxt = len_inc;
        end else begin
          em_a_v            = 1'b1;
          em_a.token_type   = (mode_r == M_IDENT) ? TOK_IDENT : TOK_NUMBER;
          em_a.token_length = TLEN_W'(len_r);
          do_idle           = 1'b1;
        end
      end
      M_SLASH: begin
        if (b == CH_SLASH) begin
          mode_nxt = M_COMMENT;
        end else begin
          em_a_v          = 1'b1;
          em_a.token_type = TOK_FSLASH;
          do_idle         = 1'b1;
        end
      end
      M_COMMENT: begin
        if (b == CH_LF) begin
          line_nxt = line_inc;
          mode_nxt = M_IDLE;
        end
      end
      M_STRING: begin
        if (b == CH_DQUOTE && !bsl_r) begin
          em_a_v            = 1'b1;
          em_a.token_type   = TOK_STRING;
          em_a.token_length = TLEN_W'(len_r);
          mode_nxt          = M_IDLE;
        end else begin
          len_nxt = len_inc;
          bsl_nxt = (b == CH_BSL);
        end
      end
      M_CHAR_BODY: begin
        em_a_v            = 1'b1;
        em_a.token_type   = TOK_CHAR;
        em_a.token_length = TLEN_W'(1);
        mode_nxt          = M_CHAR_CLOSE;
      end
      M_CHAR_CLOSE: mode_nxt = M_IDLE;
      M_ERROR:      mode_nxt = M_ERROR;
      default:      do_idle = 1'b1;
    endcase

    // between tokens: classify the byte
    em_b.token_start = START_W'(off_r);
    em_b.token_line  = LINE_W'(line_r);
    if (do_idle) begin
      mode_nxt = M_IDLE;
      if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) begin
        if (b == CH_LF) begin
          line_nxt = line_inc;
        end
      end else if (b == CH_SLASH || is_alpha_(b) || is_digit(b) ||
                   b == CH_DQUOTE || b == CH_SQUOTE) begin
        sline_nxt = line_r;
        bsl_nxt   = 1'b0;
        start_nxt = off_r;
        len_nxt   = '0;
        if (b == CH_SLASH) begin
          mode_nxt = M_SLASH;
        end else if (is_alpha_(b)) begin
          mode_nxt = M_IDENT;
          len_nxt  = LENGTH_BITS'(1);
        end else if (is_digit(b)) begin
          mode_nxt = M_NUMBER;
          len_nxt  = LENGTH_BITS'(1);
        end else if (b == CH_DQUOTE) begin
          mode_nxt  = M_STRING;
          start_nxt = off_r + 1'b1;
        end else begin
          mode_nxt  = M_CHAR_BODY;
          start_nxt = off_r + 1'b1;
        end
      end else if (pk.hit) begin
        em_b_v          = 1'b1;
        em_b.token_type = pk.kind;
      end else begin
        em_b_v          = 1'b1;
        em_b.error_flag = 1'b1;
        em_b.bad_byte   = b;
        mode_nxt        = M_ERROR;
      end
    end

    // end of file: flush what is pending, then back to reset state
    em_c.token_start  = START_W'(start_nxt);
    em_c.token_line   = LINE_W'(sline_nxt);
    em_c.token_length = TLEN_W'(len_nxt);
    if (last) begin
      case (mode_nxt)
        M_IDENT: begin
          em_c_v          = 1'b1;
          em_c.token_type = TOK_IDENT;
        end
        M_NUMBER: begin
          em_c_v          = 1'b1;
          em_c.token_type = TOK_NUMBER;
        end
        M_STRING: begin
          em_c_v          = 1'b1;
          em_c.token_type = TOK_STRING;
        end
        M_SLASH: begin
          em_c_v            = 1'b1;
          em_c.token_type   = TOK_FSLASH;
          em_c.token_length = '0;
        end
        M_CHAR_BODY: begin
          em_c_v            = 1'b1;
          em_c.token_type   = TOK_CHAR;
          em_c.token_length = '0;
        end
        default: em_c_v = 1'b0;
      endcase
      mode_nxt  = M_IDLE;
      start_nxt = '0;
      len_nxt   = '0;
      line_nxt  = LINE_BITS'(1);
      off_nxt   = '0;
      bsl_nxt   = 1'b0;
      sline_nxt = LINE_BITS'(1);
    end else begin
      off_nxt = off_r + 1'b1;
    end

    // pack up to two words in order
    res0  = em_a_v ? em_a : (em_b_v ? em_b : em_c);
    res1  = (em_a_v && em_b_v) ? em_b : em_c;
    n_res = 2'(em_a_v) + 2'(em_b_v) + 2'(em_c_v);
    if (n_res == 2'd1) begin
      res0.run_last = 1'b1;
      res0.file_end = last;
    end
    if (n_res == 2'd2) begin
      res1.run_last = 1'b1;
      res1.file_end = last;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = count_nxt + FIFO_CW'(n_res);
    end
    if (pop) begin
      count_nxt = count_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      start_r  <= '0;
      len_r    <= '0;
      line_r   <= LINE_BITS'(1);
      off_r    <= '0;
      bsl_r    <= 1'b0;
      sline_r  <= LINE_BITS'(1);
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (accept) begin
        mode_r   <= mode_nxt;
        start_r  <= start_nxt;
        len_r    <= len_nxt;
        line_r   <= line_nxt;
        off_r    <= off_nxt;
        bsl_r    <= bsl_nxt;
        sline_r  <= sline_nxt;
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(n_res);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // queue storage, payload only
  always_ff @(posedge clk) begin
    if (accept && n_res != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (accept && n_res == 2'd2) begin
      fifo_r[wr_ptr_r + 1'b1] <= res1;
    end
  end

  assign out_ch.valid        = count_r != '0;
  assign out_ch.token_type   = fifo_r[rd_ptr_r].token_type;
  assign out_ch.token_start  = fifo_r[rd_ptr_r].token_start;
  assign out_ch.token_length = fifo_r[rd_ptr_r].token_length;
  assign out_ch.token_line   = fifo_r[rd_ptr_r].token_line;
  assign out_ch.error_flag   = fifo_r[rd_ptr_r].error_flag;
  assign out_ch.bad_byte     = fifo_r[rd_ptr_r].bad_byte;
  assign out_ch.file_end     = fifo_r[rd_ptr_r].file_end;
  assign out_ch.run_last     = fifo_r[rd_ptr_r].run_last;

endmodule
